// ===== rtl/cvms_pkg.sv =====
// ----------------------------------------------------------------------------
// cvms_pkg: shared types and constants of the closest video mode selector
// Field widths, configuration register indexes and the record that the
// front part hands to the back part through the candidate queue.
// ----------------------------------------------------------------------------
`default_nettype none

package cvms_pkg;

    // Default for the MAX_MODES parameter of the top level.
    localparam int MAX_MODES_DEF = 256;

    // Field widths.
    localparam int POS_W      = 8;
    localparam int DIM_W      = 14;
    localparam int BITS_W     = 5;
    localparam int DBITS_W    = 6;
    localparam int RATE_W     = 20;
    localparam int DRATE_W    = 21;
    localparam int COLOR_W    = 6;
    localparam int SIZE_W     = 30;
    localparam int RCOST_W    = 21;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 21;

    // Candidate queue between the front and the back part.
    localparam int QUEUE_DEPTH = 4;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DESIRED_WIDTH  = 3'd0,
        CFG_DESIRED_HEIGHT = 3'd1,
        CFG_DESIRED_RED    = 3'd2,
        CFG_DESIRED_GREEN  = 3'd3,
        CFG_DESIRED_BLUE   = 3'd4,
        CFG_DESIRED_RATE   = 3'd5
    } t_cfg_index;

    // Desired mode as held in the configuration registers.
    typedef struct packed {
        logic        [DIM_W-1:0]   width;
        logic        [DIM_W-1:0]   height;
        logic signed [DBITS_W-1:0] red;
        logic signed [DBITS_W-1:0] green;
        logic signed [DBITS_W-1:0] blue;
        logic signed [DRATE_W-1:0] rate;
    } t_cfg;

    // One classified candidate: its three cost keys and what the result needs.
    typedef struct packed {
        logic [COLOR_W-1:0] color;
        logic [SIZE_W-1:0]  size;
        logic [RCOST_W-1:0] rcost;
        logic [POS_W-1:0]   pos;
        logic [DIM_W-1:0]   width;
        logic [DIM_W-1:0]   height;
        logic [RATE_W-1:0]  rate;
        logic               last;
    } t_cand;

endpackage

`default_nettype wire

// ===== rtl/cvms_front.sv =====
// ----------------------------------------------------------------------------
// cvms_front: mode intake and cost computation
// Accepts one mode word per cycle while the queue has room, numbers it
// within its list and works out its colour, size and rate costs over two stages before queueing it.
// ----------------------------------------------------------------------------
`default_nettype none

module cvms_front #(
    parameter int MAX_MODES = cvms_pkg::MAX_MODES_DEF
) (
    input  wire                             i_clk,
    input  wire                             i_rst_n,
    input  cvms_pkg::t_cfg                  i_cfg,
    input  wire                             i_mode_valid,
    output logic                            o_mode_ready,
    input  wire  [cvms_pkg::DIM_W-1:0]      i_mode_width,
    input  wire  [cvms_pkg::DIM_W-1:0]      i_mode_height,
    input  wire  [cvms_pkg::BITS_W-1:0]     i_mode_red_bits,
    input  wire  [cvms_pkg::BITS_W-1:0]     i_mode_green_bits,
    input  wire  [cvms_pkg::BITS_W-1:0]     i_mode_blue_bits,
    input  wire  [cvms_pkg::RATE_W-1:0]     i_mode_rate_mhz,
    input  wire                             i_last_mode,
    input  wire  [cvms_pkg::QCNT_W-1:0]     i_q_count,
    output logic                            o_push,
    output cvms_pkg::t_cand                 o_push_data
);

    localparam int POS_W   = cvms_pkg::POS_W;
    localparam int DIM_W   = cvms_pkg::DIM_W;
    localparam int COLOR_W = cvms_pkg::COLOR_W;
    localparam int RCOST_W = cvms_pkg::RCOST_W;
    localparam int DRATE_W = cvms_pkg::DRATE_W;
    localparam int RATE_W  = cvms_pkg::RATE_W;
    localparam int SIZE_W  = cvms_pkg::SIZE_W;
    localparam int SQ_W    = 2 * DIM_W;
    localparam int POS_MAX = (1 << POS_W) - 1;
    localparam int POS_LIM_INT = (MAX_MODES - 1 > POS_MAX) ? POS_MAX : MAX_MODES - 1;
    localparam logic [POS_W-1:0] POS_LIMIT = POS_W'(POS_LIM_INT);
    localparam int COLOR_MAX = (1 << COLOR_W) - 1;

    // Cost of one colour channel; a desired value of all ones is don't care.
    function automatic logic [COLOR_W-1:0] chan_cost(
        input logic        [cvms_pkg::BITS_W-1:0]  have,
        input logic signed [cvms_pkg::DBITS_W-1:0] want
    );
        logic signed [cvms_pkg::DBITS_W:0] diff;
        diff = $signed({2'b00, have}) - $signed({want[cvms_pkg::DBITS_W-1], want});
        if (want == '1) begin
            chan_cost = '0;
        end else if (diff < 0) begin
            chan_cost = COLOR_W'(-diff);
        end else begin
            chan_cost = COLOR_W'(diff);
        end
    endfunction

    logic                    accept;
    logic [POS_W-1:0]        r_pos;
    logic [POS_W-1:0]        n_pos;

    logic [COLOR_W+1:0]      color_sum;
    logic [COLOR_W-1:0]      color_sat;
    logic signed [DIM_W:0]   dw_s;
    logic signed [DIM_W:0]   dh_s;
    logic signed [DRATE_W:0] dr_s;
    logic [RCOST_W-1:0]      rcost;

    // Stage one: costs that need no multiplication, plus the raw fields.
    logic                    r_s1_valid;
    logic [COLOR_W-1:0]      r_s1_color;
    logic [DIM_W-1:0]        r_s1_dw;
    logic [DIM_W-1:0]        r_s1_dh;
    logic [RCOST_W-1:0]      r_s1_rcost;
    logic [POS_W-1:0]        r_s1_pos;
    logic [DIM_W-1:0]        r_s1_width;
    logic [DIM_W-1:0]        r_s1_height;
    logic [RATE_W-1:0]       r_s1_rate;
    logic                    r_s1_last;

    // Stage two: the two squares.
    logic                    r_s2_valid;
    logic [COLOR_W-1:0]      r_s2_color;
    logic [SQ_W-1:0]         r_s2_sqw;
    logic [SQ_W-1:0]         r_s2_sqh;
    logic [RCOST_W-1:0]      r_s2_rcost;
    logic [POS_W-1:0]        r_s2_pos;
    logic [DIM_W-1:0]        r_s2_width;
    logic [DIM_W-1:0]        r_s2_height;
    logic [RATE_W-1:0]       r_s2_rate;
    logic                    r_s2_last;

    logic [cvms_pkg::QCNT_W+1:0] inflight;

    // Credit check: every word in the stages already owns a queue slot.
    assign inflight = (cvms_pkg::QCNT_W+2)'(i_q_count)
                    + (cvms_pkg::QCNT_W+2)'(r_s1_valid)
                    + (cvms_pkg::QCNT_W+2)'(r_s2_valid);
    assign o_mode_ready = (inflight < (cvms_pkg::QCNT_W+2)'(cvms_pkg::QUEUE_DEPTH));
    assign accept = i_mode_valid && o_mode_ready;

    always_comb begin
        color_sum = (COLOR_W+2)'(chan_cost(i_mode_red_bits, i_cfg.red))
                  + (COLOR_W+2)'(chan_cost(i_mode_green_bits, i_cfg.green))
                  + (COLOR_W+2)'(chan_cost(i_mode_blue_bits, i_cfg.blue));
        color_sat = (color_sum > (COLOR_W+2)'(COLOR_MAX)) ? COLOR_W'(COLOR_MAX)
                                                          : color_sum[COLOR_W-1:0];

        dw_s = $signed({1'b0, i_mode_width}) - $signed({1'b0, i_cfg.width});
        dh_s = $signed({1'b0, i_mode_height}) - $signed({1'b0, i_cfg.height});

        dr_s = $signed({2'b00, i_mode_rate_mhz}) - $signed({i_cfg.rate[DRATE_W-1], i_cfg.rate});
        if (i_cfg.rate == '1) begin
            rcost = {1'b0, ~i_mode_rate_mhz};
        end else if (dr_s < 0) begin
            rcost = RCOST_W'(-dr_s);
        end else begin
            rcost = RCOST_W'(dr_s);
        end

        if (i_last_mode) begin
            n_pos = '0;
        end else if (r_pos < POS_LIMIT) begin
            n_pos = r_pos + POS_W'(1);
        end else begin
            n_pos = r_pos;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos      <= '0;
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_pos <= n_pos;
            end
            r_s1_valid <= accept;
            r_s2_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_color  <= color_sat;
            r_s1_dw     <= (dw_s < 0) ? DIM_W'(-dw_s) : DIM_W'(dw_s);
            r_s1_dh     <= (dh_s < 0) ? DIM_W'(-dh_s) : DIM_W'(dh_s);
            r_s1_rcost  <= rcost;
            r_s1_pos    <= r_pos;
            r_s1_width  <= i_mode_width;
            r_s1_height <= i_mode_height;
            r_s1_rate   <= i_mode_rate_mhz;
            r_s1_last   <= i_last_mode;
        end
        if (r_s1_valid) begin
            r_s2_color  <= r_s1_color;
            r_s2_sqw    <= r_s1_dw * r_s1_dw;
            r_s2_sqh    <= r_s1_dh * r_s1_dh;
            r_s2_rcost  <= r_s1_rcost;
            r_s2_pos    <= r_s1_pos;
            r_s2_width  <= r_s1_width;
            r_s2_height <= r_s1_height;
            r_s2_rate   <= r_s1_rate;
            r_s2_last   <= r_s1_last;
        end
    end

    always_comb begin
        o_push             = r_s2_valid;
        o_push_data.color  = r_s2_color;
        o_push_data.size   = SIZE_W'(r_s2_sqw) + SIZE_W'(r_s2_sqh);
        o_push_data.rcost  = r_s2_rcost;
        o_push_data.pos    = r_s2_pos;
        o_push_data.width  = r_s2_width;
        o_push_data.height = r_s2_height;
        o_push_data.rate   = r_s2_rate;
        o_push_data.last   = r_s2_last;
    end

endmodule

`default_nettype wire

// ===== rtl/cvms_queue.sv =====
// ----------------------------------------------------------------------------
// cvms_queue: candidate queue
// Small first-in first-out store of classified candidates between the front
// and the back part.
// ----------------------------------------------------------------------------
`default_nettype none

module cvms_queue (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          i_push,
    input  cvms_pkg::t_cand              i_push_data,
    input  wire                          i_pop,
    output logic                         o_nonempty,
    output cvms_pkg::t_cand              o_head,
    output logic [cvms_pkg::QCNT_W-1:0]  o_count
);

    localparam int DEPTH = cvms_pkg::QUEUE_DEPTH;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW    = cvms_pkg::QCNT_W;

    cvms_pkg::t_cand r_mem [DEPTH];
    logic [AW-1:0]   r_wr_ptr;
    logic [AW-1:0]   r_rd_ptr;
    logic [CW-1:0]   r_count;
    logic [AW-1:0]   n_wr_ptr;
    logic [AW-1:0]   n_rd_ptr;
    logic            do_pop;

    assign do_pop     = i_pop && (r_count != '0);
    assign o_nonempty = (r_count != '0);
    assign o_head     = r_mem[r_rd_ptr];
    assign o_count    = r_count;

    assign n_wr_ptr = (r_wr_ptr == AW'(DEPTH - 1)) ? '0 : r_wr_ptr + AW'(1);
    assign n_rd_ptr = (r_rd_ptr == AW'(DEPTH - 1)) ? '0 : r_rd_ptr + AW'(1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= n_wr_ptr;
            end
            if (do_pop) begin
                r_rd_ptr <= n_rd_ptr;
            end
            if (i_push && !do_pop) begin
                r_count <= r_count + CW'(1);
            end else if (!i_push && do_pop) begin
                r_count <= r_count - CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_push_data;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/cvms_back.sv =====
// ----------------------------------------------------------------------------
// cvms_back: running-best compare and result register
// Compares each queued candidate with the running best by colour, size and
// rate cost, and emits the winner when the last mode of a list comes through.
// ----------------------------------------------------------------------------
`default_nettype none

module cvms_back (
    input  wire                             i_clk,
    input  wire                             i_rst_n,
    input  wire                             i_head_valid,
    input  cvms_pkg::t_cand                 i_head,
    output logic                            o_pop,
    output logic                            o_best_valid,
    input  wire                             i_best_ready,
    output logic [cvms_pkg::POS_W-1:0]      o_best_index,
    output logic [cvms_pkg::DIM_W-1:0]      o_best_width,
    output logic [cvms_pkg::DIM_W-1:0]      o_best_height,
    output logic [cvms_pkg::RATE_W-1:0]     o_best_rate_mhz
);

    logic                                r_have;
    logic [cvms_pkg::COLOR_W-1:0]        r_color;
    logic [cvms_pkg::SIZE_W-1:0]         r_size;
    logic [cvms_pkg::RCOST_W-1:0]        r_rcost;
    logic [cvms_pkg::POS_W-1:0]          r_pos;
    logic [cvms_pkg::DIM_W-1:0]          r_width;
    logic [cvms_pkg::DIM_W-1:0]          r_height;
    logic [cvms_pkg::RATE_W-1:0]         r_rate;

    logic                                r_out_valid;
    logic [cvms_pkg::POS_W-1:0]          r_out_index;
    logic [cvms_pkg::DIM_W-1:0]          r_out_width;
    logic [cvms_pkg::DIM_W-1:0]          r_out_height;
    logic [cvms_pkg::RATE_W-1:0]         r_out_rate;

    logic                                take;
    logic                                out_free;

    // Strictly better only, so ties keep the earlier mode.
    assign take = !r_have
               || (i_head.color < r_color)
               || ((i_head.color == r_color) && (i_head.size < r_size))
               || ((i_head.color == r_color) && (i_head.size == r_size)
                   && (i_head.rcost < r_rcost));

    assign out_free = !r_out_valid || i_best_ready;
    assign o_pop    = i_head_valid && (!i_head.last || out_free);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_have      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_pop) begin
                r_have <= !i_head.last;
            end
            if (o_pop && i_head.last) begin
                r_out_valid <= 1'b1;
            end else if (i_best_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop && take) begin
            r_color  <= i_head.color;
            r_size   <= i_head.size;
            r_rcost  <= i_head.rcost;
            r_pos    <= i_head.pos;
            r_width  <= i_head.width;
            r_height <= i_head.height;
            r_rate   <= i_head.rate;
        end
        if (o_pop && i_head.last) begin
            r_out_index  <= take ? i_head.pos    : r_pos;
            r_out_width  <= take ? i_head.width  : r_width;
            r_out_height <= take ? i_head.height : r_height;
            r_out_rate   <= take ? i_head.rate   : r_rate;
        end
    end

    assign o_best_valid    = r_out_valid;
    assign o_best_index    = r_out_index;
    assign o_best_width    = r_out_width;
    assign o_best_height   = r_out_height;
    assign o_best_rate_mhz = r_out_rate;

endmodule

`default_nettype wire

// ===== rtl/closest_video_mode_selector.sv =====
// ----------------------------------------------------------------------------
// closest_video_mode_selector: picks the display mode closest to a target
// Streams a list of modes and returns the position, size and refresh rate of
// the one that best matches the configured target mode.
// ----------------------------------------------------------------------------
// The block takes one mode word per clock and, on the word flagged as the
// last of its list, returns one result word naming the closest mode. Modes
// are ranked first by the summed colour-depth mismatch (a target depth of -1
// ignores that channel, and the sum saturates at 63), then by the squared
// distance in width and height, then by the refresh mismatch in millihertz,
// where a target rate of -1 ranks the fastest mode best. Only a strictly
// better mode replaces the running best, so ties go to the earlier mode.
// Positions count from zero and stop at MAX_MODES-1 or 255, whichever is
// smaller. Throughput is one mode per cycle while input ready is high; a
// mode word passes the two cost stages, a four-entry queue and the compare
// stage before the result register takes the winner of its list. Input
// ready follows the free slots of the queue: it drops only when the result
// register stays full and the queue fills behind it. The target registers
// must be written only while the block is idle.
// ----------------------------------------------------------------------------
`default_nettype none

module closest_video_mode_selector #(
    parameter int MAX_MODES = cvms_pkg::MAX_MODES_DEF
) (
    input  wire                                i_clk,
    input  wire                                i_rst_n,
    // Configuration write port.
    input  wire                                i_cfg_we,
    input  wire  [cvms_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  wire  [cvms_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    // Mode words in.
    input  wire                                i_mode_valid,
    output logic                               o_mode_ready,
    input  wire  [cvms_pkg::DIM_W-1:0]         i_mode_width,
    input  wire  [cvms_pkg::DIM_W-1:0]         i_mode_height,
    input  wire  [cvms_pkg::BITS_W-1:0]        i_mode_red_bits,
    input  wire  [cvms_pkg::BITS_W-1:0]        i_mode_green_bits,
    input  wire  [cvms_pkg::BITS_W-1:0]        i_mode_blue_bits,
    input  wire  [cvms_pkg::RATE_W-1:0]        i_mode_rate_mhz,
    input  wire                                i_last_mode,
    // Result words out.
    output logic                               o_best_valid,
    input  wire                                i_best_ready,
    output logic [cvms_pkg::POS_W-1:0]         o_best_index,
    output logic [cvms_pkg::DIM_W-1:0]         o_best_width,
    output logic [cvms_pkg::DIM_W-1:0]         o_best_height,
    output logic [cvms_pkg::RATE_W-1:0]        o_best_rate_mhz
);

    // Target mode registers. The signed ones come out of reset as -1, which
    // is the don't-care / prefer-highest setting.
    cvms_pkg::t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.width  <= '0;
            r_cfg.height <= '0;
            r_cfg.red    <= '1;
            r_cfg.green  <= '1;
            r_cfg.blue   <= '1;
            r_cfg.rate   <= '1;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                cvms_pkg::CFG_DESIRED_WIDTH: begin
                    r_cfg.width <= i_cfg_data[cvms_pkg::DIM_W-1:0];
                end
                cvms_pkg::CFG_DESIRED_HEIGHT: begin
                    r_cfg.height <= i_cfg_data[cvms_pkg::DIM_W-1:0];
                end
                cvms_pkg::CFG_DESIRED_RED: begin
                    r_cfg.red <= i_cfg_data[cvms_pkg::DBITS_W-1:0];
                end
                cvms_pkg::CFG_DESIRED_GREEN: begin
                    r_cfg.green <= i_cfg_data[cvms_pkg::DBITS_W-1:0];
                end
                cvms_pkg::CFG_DESIRED_BLUE: begin
                    r_cfg.blue <= i_cfg_data[cvms_pkg::DBITS_W-1:0];
                end
                cvms_pkg::CFG_DESIRED_RATE: begin
                    r_cfg.rate <= i_cfg_data[cvms_pkg::DRATE_W-1:0];
                end
                default: begin
                    // Indexes past the register list are ignored.
                end
            endcase
        end
    end

    logic                          push;
    cvms_pkg::t_cand               push_data;
    logic                          pop;
    logic                          head_valid;
    cvms_pkg::t_cand               head;
    logic [cvms_pkg::QCNT_W-1:0]   q_count;

    // Front part: numbering and the three cost keys.
    cvms_front #(
        .MAX_MODES (MAX_MODES)
    ) u_front (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg             (r_cfg),
        .i_mode_valid      (i_mode_valid),
        .o_mode_ready      (o_mode_ready),
        .i_mode_width      (i_mode_width),
        .i_mode_height     (i_mode_height),
        .i_mode_red_bits   (i_mode_red_bits),
        .i_mode_green_bits (i_mode_green_bits),
        .i_mode_blue_bits  (i_mode_blue_bits),
        .i_mode_rate_mhz   (i_mode_rate_mhz),
        .i_last_mode       (i_last_mode),
        .i_q_count         (q_count),
        .o_push            (push),
        .o_push_data       (push_data)
    );

    // Queue that lets the back part stall on a full result register while
    // the front keeps working.
    cvms_queue u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_push_data (push_data),
        .i_pop       (pop),
        .o_nonempty  (head_valid),
        .o_head      (head),
        .o_count     (q_count)
    );

    // Back part: running best and the result register.
    cvms_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_head_valid    (head_valid),
        .i_head          (head),
        .o_pop           (pop),
        .o_best_valid    (o_best_valid),
        .i_best_ready    (i_best_ready),
        .o_best_index    (o_best_index),
        .o_best_width    (o_best_width),
        .o_best_height   (o_best_height),
        .o_best_rate_mhz (o_best_rate_mhz)
    );

endmodule

`default_nettype wire

// ===== rtl/cvms_checker.sv =====
// ----------------------------------------------------------------------------
// cvms_checker: port-level checks of the closest video mode selector
// Watches the ports over time and is bound to every instance of the top.
// ----------------------------------------------------------------------------
`default_nettype none

module cvms_checker #(
    parameter int MAX_MODES = cvms_pkg::MAX_MODES_DEF
) (
    input wire                             i_clk,
    input wire                             i_rst_n,
    input wire                             i_mode_valid,
    input wire                             o_mode_ready,
    input wire                             i_last_mode,
    input wire                             o_best_valid,
    input wire                             i_best_ready,
    input wire [cvms_pkg::POS_W-1:0]       o_best_index,
    input wire [cvms_pkg::DIM_W-1:0]       o_best_width,
    input wire [cvms_pkg::DIM_W-1:0]       o_best_height,
    input wire [cvms_pkg::RATE_W-1:0]      o_best_rate_mhz
);

    localparam int POS_W   = cvms_pkg::POS_W;
    localparam int POS_MAX = (1 << POS_W) - 1;
    localparam logic [POS_W-1:0] POS_LIMIT =
        POS_W'((MAX_MODES - 1 > POS_MAX) ? POS_MAX : MAX_MODES - 1);

    // Lists closed at the input whose result word has not yet left.
    logic [7:0] r_open_lists;
    logic       last_in;
    logic       word_out;

    assign last_in  = i_mode_valid && o_mode_ready && i_last_mode;
    assign word_out = o_best_valid && i_best_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_open_lists <= '0;
        end else if (last_in && !word_out) begin
            r_open_lists <= r_open_lists + 8'd1;
        end else if (!last_in && word_out) begin
            r_open_lists <= r_open_lists - 8'd1;
        end
    end

    a_result_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_best_valid && !i_best_ready |=> o_best_valid && $stable(o_best_index)
            && $stable(o_best_width) && $stable(o_best_height)
            && $stable(o_best_rate_mhz))
        else $error("result word changed while stalled");

    a_result_has_list: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_best_valid |-> r_open_lists != 8'd0)
        else $error("result word without a closed mode list");

    a_index_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_best_valid |-> o_best_index <= POS_LIMIT)
        else $error("result index beyond the position limit");

    a_quiet_after_reset: assert property (@(posedge i_clk)
        $rose(i_rst_n) |-> !o_best_valid)
        else $error("result word presented straight out of reset");

endmodule

bind closest_video_mode_selector cvms_checker #(
    .MAX_MODES (MAX_MODES)
) u_cvms_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_mode_valid    (i_mode_valid),
    .o_mode_ready    (o_mode_ready),
    .i_last_mode     (i_last_mode),
    .o_best_valid    (o_best_valid),
    .i_best_ready    (i_best_ready),
    .o_best_index    (o_best_index),
    .o_best_width    (o_best_width),
    .o_best_height   (o_best_height),
    .o_best_rate_mhz (o_best_rate_mhz)
);

`default_nettype wire

// ===== test/closest_video_mode_selector_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// closest_video_mode_selector_test: self-checking bench for the mode selector
// Streams lists of candidate display modes through the block under several
// target settings and idle mixes. A scoreboard ranks every accepted mode by
// colour, size and refresh mismatch, and holds the winner of each list until
// the matching result word is checked field by field.
// ----------------------------------------------------------------------------

import cvms_pkg::*;

localparam int RATE_TOP  = (1 << RATE_W) - 1;
localparam int COLOR_CAP = 63;
localparam int POS_LAST  = (MAX_MODES_DEF - 1 > 255) ? 255 : MAX_MODES_DEF - 1;

// One candidate mode as it crosses the input handshake.
typedef struct packed {
    logic [DIM_W-1:0]  width;
    logic [DIM_W-1:0]  height;
    logic [BITS_W-1:0] red;
    logic [BITS_W-1:0] green;
    logic [BITS_W-1:0] blue;
    logic [RATE_W-1:0] rate;
    logic              last;
} mode_word_t;

// The winner of one list as it crosses the output handshake.
typedef struct packed {
    logic [POS_W-1:0]  index;
    logic [DIM_W-1:0]  width;
    logic [DIM_W-1:0]  height;
    logic [RATE_W-1:0] rate;
} best_word_t;

class mode_choice_board;
    int unsigned       want_width, want_height;
    int                want_red, want_green, want_blue, want_rate;
    int unsigned       position;
    bit                have_best;
    int unsigned       best_color;
    longint unsigned   best_size;
    int unsigned       best_rcost;
    best_word_t        best;
    best_word_t        expected_best_q[$];
    int unsigned       errors, modes_seen, lists_seen, results_checked;

    function new();
        want_width  = 0;
        want_height = 0;
        want_red    = -1;
        want_green  = -1;
        want_blue   = -1;
        want_rate   = -1;
        errors = 0;
        modes_seen = 0;
        lists_seen = 0;
        results_checked = 0;
        clear_list();
    endfunction

    function void clear_list();
        position   = 0;
        have_best  = 1'b0;
        best_color = 0;
        best_size  = 0;
        best_rcost = 0;
        best       = '0;
    endfunction

    function void write_target(t_cfg_index idx, logic [CFG_DATA_W-1:0] data);
        case (idx)
            CFG_DESIRED_WIDTH:  want_width  = data[DIM_W-1:0];
            CFG_DESIRED_HEIGHT: want_height = data[DIM_W-1:0];
            CFG_DESIRED_RED:    want_red    = $signed(data[DBITS_W-1:0]);
            CFG_DESIRED_GREEN:  want_green  = $signed(data[DBITS_W-1:0]);
            CFG_DESIRED_BLUE:   want_blue   = $signed(data[DBITS_W-1:0]);
            CFG_DESIRED_RATE:   want_rate   = $signed(data[DRATE_W-1:0]);
            default: ;
        endcase
    endfunction

    // Only -1 means the channel is ignored; any other value is a plain number.
    function int unsigned channel_cost(logic [BITS_W-1:0] bits, int want);
        int d;
        if (want == -1)
            return 0;
        d = int'(bits) - want;
        return (d < 0) ? -d : d;
    endfunction

    // A mode that no other mode can beat under the current target.
    function mode_word_t ideal_mode();
        mode_word_t m;
        m.width  = want_width;
        m.height = want_height;
        m.red    = (want_red   == -1) ? 8 : (want_red   < 0) ? 0 : want_red;
        m.green  = (want_green == -1) ? 8 : (want_green < 0) ? 0 : want_green;
        m.blue   = (want_blue  == -1) ? 8 : (want_blue  < 0) ? 0 : want_blue;
        m.rate   = (want_rate  == -1) ? RATE_TOP : (want_rate < 0) ? 0 : want_rate;
        m.last   = 1'b0;
        return m;
    endfunction

    function void note_mode(mode_word_t m);
        int unsigned     color, rcost;
        longint          dw, dh;
        longint unsigned size;
        int              rdiff;
        bit              take;
        color = channel_cost(m.red, want_red) + channel_cost(m.green, want_green)
              + channel_cost(m.blue, want_blue);
        if (color > COLOR_CAP)
            color = COLOR_CAP;
        dw = longint'(m.width) - longint'(want_width);
        dh = longint'(m.height) - longint'(want_height);
        if (dw < 0) dw = -dw;
        if (dh < 0) dh = -dh;
        size = dw * dw + dh * dh;
        if (want_rate == -1) begin
            rcost = RATE_TOP - int'(m.rate);
        end else begin
            rdiff = int'(m.rate) - want_rate;
            rcost = (rdiff < 0) ? -rdiff : rdiff;
        end
        take = !have_best || color < best_color
            || (color == best_color && size < best_size)
            || (color == best_color && size == best_size && rcost < best_rcost);
        if (take) begin
            have_best   = 1'b1;
            best_color  = color;
            best_size   = size;
            best_rcost  = rcost;
            best.index  = position[POS_W-1:0];
            best.width  = m.width;
            best.height = m.height;
            best.rate   = m.rate;
        end
        if (position < POS_LAST)
            position++;
        modes_seen++;
        if (m.last) begin
            expected_best_q.push_back(best);
            lists_seen++;
            clear_list();
        end
    endfunction

    function void compare_field(string name, int unsigned want, int unsigned got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
            errors++;
        end
    endfunction

    function void check_best(best_word_t got);
        best_word_t want;
        if (expected_best_q.size() == 0) begin
            $display("%0t: result word with no list pending, index %0d width %0d",
                     $time, got.index, got.width);
            errors++;
            return;
        end
        want = expected_best_q.pop_front();
        results_checked++;
        compare_field("best_index", want.index, got.index);
        compare_field("best_width", want.width, got.width);
        compare_field("best_height", want.height, got.height);
        compare_field("best_rate_mhz", want.rate, got.rate);
    endfunction
endclass

module closest_video_mode_selector_test;

    // A working run ends well before this limit; the limit only catches a
    // hung handshake.
    localparam int CLOCK_LIMIT   = 300000;
    // Length of the long result hold-off that forces the block to fill up.
    localparam int HOLD_CYCLES   = 300;
    // Extra wait after the last result has been checked; this is margin.
    localparam int SETTLE_CYCLES = 12;
    localparam int LONG_LIST     = 270;

    logic                  i_clk             = 1'b0;
    logic                  i_rst_n           = 1'b0;
    logic                  i_cfg_we          = 1'b0;
    t_cfg_index            i_cfg_index       = CFG_DESIRED_WIDTH;
    logic [CFG_DATA_W-1:0] i_cfg_data        = '0;
    logic                  i_mode_valid      = 1'b0;
    logic [DIM_W-1:0]      i_mode_width      = '0;
    logic [DIM_W-1:0]      i_mode_height     = '0;
    logic [BITS_W-1:0]     i_mode_red_bits   = '0;
    logic [BITS_W-1:0]     i_mode_green_bits = '0;
    logic [BITS_W-1:0]     i_mode_blue_bits  = '0;
    logic [RATE_W-1:0]     i_mode_rate_mhz   = '0;
    logic                  i_last_mode       = 1'b0;
    logic                  i_best_ready      = 1'b0;
    logic                  o_mode_ready;
    logic                  o_best_valid;
    logic [POS_W-1:0]      o_best_index;
    logic [DIM_W-1:0]      o_best_width;
    logic [DIM_W-1:0]      o_best_height;
    logic [RATE_W-1:0]     o_best_rate_mhz;

    mode_choice_board board = new();

    // Idle mix of the current phase, in percent of cycles.
    int          send_idle_pct = 0;
    int          stall_pct     = 0;
    // The main sequence asks for a hold-off by bumping hold_requests; the
    // receiver process counts out the stretch on its own.
    int unsigned hold_requests = 0;
    int unsigned hold_served   = 0;
    int          hold_left     = 0;
    int unsigned cycle_count        = 0;
    int unsigned input_stall_cycles = 0;

    closest_video_mode_selector dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data),
        .i_mode_valid      (i_mode_valid),
        .o_mode_ready      (o_mode_ready),
        .i_mode_width      (i_mode_width),
        .i_mode_height     (i_mode_height),
        .i_mode_red_bits   (i_mode_red_bits),
        .i_mode_green_bits (i_mode_green_bits),
        .i_mode_blue_bits  (i_mode_blue_bits),
        .i_mode_rate_mhz   (i_mode_rate_mhz),
        .i_last_mode       (i_last_mode),
        .o_best_valid      (o_best_valid),
        .i_best_ready      (i_best_ready),
        .o_best_index      (o_best_index),
        .o_best_width      (o_best_width),
        .o_best_height     (o_best_height),
        .o_best_rate_mhz   (o_best_rate_mhz)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Watchdog: a stuck handshake ends the run here.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CLOCK_LIMIT) begin
            $display("Run stopped by the watchdog after %0d cycles.", cycle_count);
            $display("TEST FAILED");
            $finish;
        end
    end

    // Both monitors look at the values from before the edge: every input is
    // driven with nonblocking assignments, and the block's registers settle
    // only after this process has run.
    always @(posedge i_clk) begin
        if (i_rst_n && i_mode_valid && o_mode_ready)
            board.note_mode({i_mode_width, i_mode_height, i_mode_red_bits,
                             i_mode_green_bits, i_mode_blue_bits, i_mode_rate_mhz,
                             i_last_mode});
        if (i_rst_n && i_mode_valid && !o_mode_ready)
            input_stall_cycles++;
        if (i_rst_n && o_best_valid && i_best_ready)
            board.check_best({o_best_index, o_best_width, o_best_height,
                              o_best_rate_mhz});
    end

    // Result side: random stalls at the phase's rate, or a long hold-off when
    // one has been asked for.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_best_ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
            i_best_ready <= 1'b0;
        end else if (hold_served != hold_requests) begin
            hold_served++;
            hold_left = HOLD_CYCLES - 1;
            i_best_ready <= 1'b0;
        end else begin
            i_best_ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    function automatic mode_word_t mode_of(int w, int h, int r, int g, int b,
                                           int rate, bit last);
        mode_word_t m;
        m.width  = w;
        m.height = h;
        m.red    = r;
        m.green  = g;
        m.blue   = b;
        m.rate   = rate;
        m.last   = last;
        return m;
    endfunction

    // Mix of exact hits, near misses, extremes and anything in range, so that
    // ties and every comparison key get exercised.
    function automatic int unsigned pick_value(int unsigned ideal, int unsigned top);
        int v;
        case ($urandom_range(3))
            0: return ideal;
            1: begin
                v = int'(ideal) + int'($urandom_range(8)) - 4;
                if (v < 0)
                    v = 0;
                if (v > int'(top))
                    v = top;
                return v;
            end
            2: return $urandom_range(top);
            default: return ($urandom_range(1) == 0) ? 0 : top;
        endcase
    endfunction

    function automatic mode_word_t random_mode(bit last);
        mode_word_t  m, ideal;
        int unsigned bits_top;
        ideal = board.ideal_mode();
        // Depths above 16 are rare but legal on the port.
        bits_top = ($urandom_range(15) == 0) ? 31 : 16;
        m.width  = pick_value(ideal.width, 16383);
        m.height = pick_value(ideal.height, 16383);
        m.red    = pick_value(ideal.red, bits_top);
        m.green  = pick_value(ideal.green, bits_top);
        m.blue   = pick_value(ideal.blue, bits_top);
        m.rate   = pick_value(ideal.rate, RATE_TOP);
        m.last   = last;
        return m;
    endfunction

    // Offers one mode word and returns on the edge that accepts it. Valid is
    // left high so that a back-to-back word needs no second assignment.
    task automatic send_mode(mode_word_t m);
        if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
            i_mode_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < send_idle_pct);
        end
        i_mode_valid <= 1'b1;
        {i_mode_width, i_mode_height, i_mode_red_bits, i_mode_green_bits,
         i_mode_blue_bits, i_mode_rate_mhz, i_last_mode} <= m;
        do @(posedge i_clk); while (!o_mode_ready);
    endtask

    // Stops offering words and waits until every list has produced its result.
    // One edge passes first so that the monitor has noted the final word.
    task automatic wait_idle();
        i_mode_valid <= 1'b0;
        @(posedge i_clk);
        while (board.expected_best_q.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic cfg_write(t_cfg_index idx, int value);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value[CFG_DATA_W-1:0];
        @(posedge i_clk);
        board.write_target(idx, value[CFG_DATA_W-1:0]);
    endtask

    // Writes all six target registers; only called while the block is idle.
    task automatic set_target(int w, int h, int r, int g, int b, int rate);
        cfg_write(CFG_DESIRED_WIDTH, w);
        cfg_write(CFG_DESIRED_HEIGHT, h);
        cfg_write(CFG_DESIRED_RED, r);
        cfg_write(CFG_DESIRED_GREEN, g);
        cfg_write(CFG_DESIRED_BLUE, b);
        cfg_write(CFG_DESIRED_RATE, rate);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    // Mostly short lists, now and then a longer one.
    task automatic run_lists(int items);
        int sent, len;
        sent = 0;
        while (sent < items) begin
            len = ($urandom_range(7) == 0) ? $urandom_range(24, 7) : $urandom_range(6, 1);
            for (int k = 0; k < len; k++)
                send_mode(random_mode(k == len - 1));
            sent += len;
        end
    endtask

    // A list longer than the position counter. Everything before the counter
    // tops out is kept off target, so the first perfect match after that
    // point wins and must report the saturated index.
    task automatic long_list();
        mode_word_t m, ideal;
        ideal = board.ideal_mode();
        for (int k = 0; k < LONG_LIST; k++) begin
            if (k >= 258 && k % 4 == 2) begin
                m = ideal;
            end else begin
                m = random_mode(1'b0);
                m.width = ideal.width ^ 14'd1;
            end
            m.last = (k == LONG_LIST - 1);
            send_mode(m);
        end
    endtask

    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset target: 0x0, all depths ignored, fastest rate preferred.
        // A one-mode list at the top of every field reports index 0.
        send_mode(mode_of(16383, 16383, 31, 31, 31, RATE_TOP, 1'b1));
        // Same size everywhere, so the faster second mode wins and the equal
        // third one loses the tie.
        send_mode(mode_of(0, 0, 0, 0, 0, 0, 1'b0));
        send_mode(mode_of(0, 0, 16, 16, 16, 1000, 1'b0));
        send_mode(mode_of(0, 0, 8, 8, 8, 1000, 1'b1));
        wait_idle();

        // Each key in turn decides: colour, then size, then rate, and an equal
        // rate distance keeps the earlier mode.
        set_target(1920, 1080, 8, 8, 8, 60000);
        send_mode(mode_of(1920, 1080, 10, 10, 10, 60000, 1'b0));
        send_mode(mode_of(1280, 720, 8, 8, 8, 60000, 1'b0));
        send_mode(mode_of(1920, 1080, 8, 8, 8, 50000, 1'b0));
        send_mode(mode_of(1920, 1080, 8, 8, 8, 59940, 1'b0));
        send_mode(mode_of(1920, 1080, 8, 8, 8, 60060, 1'b0));
        send_mode(mode_of(1920, 1080, 0, 16, 31, 60000, 1'b1));
        wait_idle();

        // Out-of-range depths are plain numbers, so all three colour sums saturate
        // and size, then rate, decides; the most negative rate gives the largest rate cost.
        set_target(16383, 16383, -32, 31, -2, -1048576);
        send_mode(mode_of(0, 0, 31, 31, 31, RATE_TOP, 1'b0));
        send_mode(mode_of(16383, 16383, 0, 0, 0, 0, 1'b0));
        send_mode(mode_of(16383, 16383, 0, 0, 0, RATE_TOP, 1'b1));
        wait_idle();

        // Hold the result side for a long stretch while one-mode lists keep
        // coming, so the queue fills and input ready must drop.
        hold_requests++;
        for (int k = 0; k < 40; k++)
            send_mode(random_mode(1'b1));
        wait_idle();

        // Phase with no idling at all, including the over-long list.
        set_target(0, 16383, 16, -1, 0, 1048575);
        long_list();
        run_lists(230);
        wait_idle();

        // Sender idles about half the time against a random in-range target.
        send_idle_pct = 52;
        set_target($urandom_range(16383), $urandom_range(16383),
                   int'($urandom_range(17)) - 1, int'($urandom_range(17)) - 1,
                   int'($urandom_range(17)) - 1, -1);
        run_lists(230);
        wait_idle();

        // Receiver stalls about half the time; colour ignored entirely.
        send_idle_pct = 0;
        stall_pct     = 52;
        set_target(16383, 0, -1, -1, -1, 0);
        run_lists(230);
        wait_idle();

        // Both sides idle; depths and rate anywhere in their register range.
        send_idle_pct = 31;
        stall_pct     = 31;
        set_target($urandom_range(16383), $urandom_range(16383),
                   int'($urandom_range(63)) - 32, int'($urandom_range(63)) - 32,
                   int'($urandom_range(63)) - 32,
                   int'($urandom_range(2097151)) - 1048576);
        run_lists(230);
        wait_idle();

        $display("Checked %0d results from %0d lists holding %0d modes, over seven targets",
                 board.results_checked, board.lists_seen, board.modes_seen);
        $display("and four idle mixes; input held back %0d cycles, %0d errors seen.",
                 input_stall_cycles, board.errors);
        if (board.errors == 0 && board.expected_best_q.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/cvms_pkg.sv
rtl/cvms_front.sv
rtl/cvms_queue.sv
rtl/cvms_back.sv
rtl/closest_video_mode_selector.sv
rtl/cvms_checker.sv
test/closest_video_mode_selector_test.sv
